// ===== hw/rtl/btsp_pkg.sv =====
// Shared types and constants for the boot table stream parser.
// Used by the front, queue, back and top-level modules; no dependencies.
package btsp_pkg;

  // Default settings
  localparam int unsigned HEADER_WORDS_DEFAULT = 11;
  localparam int unsigned QUEUE_DEPTH_DEFAULT  = 4;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned ADDR_W = 32;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_BLOCK = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  // Operations handed from front to back
  typedef enum logic [1:0] {
    OP_ADDR_H = 2'd0,
    OP_ADDR_L = 2'd1,
    OP_DATA   = 2'd2,
    OP_END    = 2'd3
  } op_t;

  // Input item
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              image_start;
  } in_item_t;

  // Result item
  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] target_address;
    logic [WORD_W-1:0] data_word;
  } out_item_t;

  // Classified command in the queue
  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] size;
  } cmd_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== hw/rtl/boot_table_stream_parser.sv =====
// Boot table stream parser, top level.
// Depends on btsp_pkg, btsp_front, btsp_queue and btsp_back.
//
// Usage:
//   src channel: one 16-bit boot image word per item, with image_start
//   flagging the key word of a new image. The parser skips HEADER_WORDS
//   header words, then reads blocks (size, high address, low address, data).
//   res channel: one result per data word (KIND_DATA, its target address),
//   per block start (KIND_BLOCK, start address and size) and at a zero size
//   word (KIND_END). Header, size and address-high words give no result.
//   Throughput: one item per cycle in both directions, sustained while res_stall
//   is low; a held result lets the command queue fill and raise src_stall.
//   Path: with the queue empty, an accepted word is written into the command
//   queue, then its result is loaded into the result register; queued commands ahead of it go first.
//   Stall: a stalled result holds; the parser keeps accepting until the
//   QUEUE_DEPTH-entry command queue fills, then raises src_stall.
//   Reset (rst, synchronous): parser returns to the header phase, queue and
//   result register empty. The first word after reset counts as a header
//   word whether flagged or not.
module boot_table_stream_parser import btsp_pkg::*; #(
  parameter int unsigned HEADER_WORDS = HEADER_WORDS_DEFAULT,
  parameter int unsigned QUEUE_DEPTH  = QUEUE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  output logic      src_stall,
  input  in_item_t  src_item,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res_item
);

  logic      accept;
  logic      push;
  logic      pop;
  cmd_t      push_cmd;
  cmd_t      head;
  q_status_t q_status;

  assign src_stall = q_status.full;
  assign accept    = src_valid && !src_stall;

  btsp_front #(
    .HEADER_WORDS(HEADER_WORDS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (src_item),
    .push   (push),
    .cmd    (push_cmd)
  );

  btsp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  btsp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!q_status.empty),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item)
  );

  // Front never writes a full queue
  assert property (@(posedge clk) disable iff (rst) push |-> !q_status.full)
    else $error("command pushed into full queue");

  // Back never pops an empty queue
  assert property (@(posedge clk) disable iff (rst) pop |-> !q_status.empty)
    else $error("command popped from empty queue");

  // End of table carries zero address and data
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_item.kind == KIND_END) |->
      (res_item.target_address == '0 && res_item.data_word == '0))
    else $error("end of table result with nonzero payload");

  // A popped address-high word yields no new result
  assert property (@(posedge clk) disable iff (rst)
    (pop && head.op == OP_ADDR_H && !res_valid) |=> !res_valid)
    else $error("address-high command produced a result");

endmodule

// ===== hw/rtl/btsp_front.sv =====
// Front end: accepts stream words, tracks header/block phase, classifies.
// Depends on btsp_pkg; feeds commands into btsp_queue.
module btsp_front import btsp_pkg::*; #(
  parameter int unsigned HEADER_WORDS = HEADER_WORDS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  in_item_t  item,
  output logic      push,
  output cmd_t      cmd
);

  localparam int unsigned CNT_W = $clog2(HEADER_WORDS + 1);

  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_SIZE   = 6'b000010,
    PH_ADDR_H = 6'b000100,
    PH_ADDR_L = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  phase_t             phase, phase_next;
  logic [CNT_W-1:0]   header_count, header_count_next;
  logic [WORD_W-1:0]  words_left, words_left_next;
  logic [CNT_W-1:0]   count_inc;

  assign count_inc = header_count + CNT_W'(1);

  // Classify the word and advance the phase
  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    words_left_next   = words_left;
    push              = 1'b0;
    cmd.op            = OP_DATA;
    cmd.word          = item.word;
    cmd.size          = words_left;
    if (item.image_start) begin
      // new image: key word counts as header word one
      header_count_next = CNT_W'(1);
      words_left_next   = '0;
      phase_next        = (HEADER_WORDS <= 1) ? PH_SIZE : PH_HEADER;
    end else begin
      case (phase)
        PH_HEADER: begin
          header_count_next = count_inc;
          if (count_inc >= CNT_W'(HEADER_WORDS)) phase_next = PH_SIZE;
        end
        PH_SIZE: begin
          if (item.word == '0) begin
            phase_next = PH_DONE;
            push       = 1'b1;
            cmd.op     = OP_END;
          end else begin
            words_left_next = item.word;
            phase_next      = PH_ADDR_H;
          end
        end
        PH_ADDR_H: begin
          push       = 1'b1;
          cmd.op     = OP_ADDR_H;
          phase_next = PH_ADDR_L;
        end
        PH_ADDR_L: begin
          push       = 1'b1;
          cmd.op     = OP_ADDR_L;
          phase_next = PH_DATA;
        end
        PH_DATA: begin
          push            = 1'b1;
          cmd.op          = OP_DATA;
          words_left_next = words_left - WORD_W'(1);
          if (words_left == WORD_W'(1)) phase_next = PH_SIZE;
        end
        PH_DONE: begin
          // ignore until a flagged word
        end
        default: begin
          phase_next = PH_HEADER;
        end
      endcase
    end
    if (!accept) begin
      phase_next        = phase;
      header_count_next = header_count;
      words_left_next   = words_left;
      push              = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_count <= '0;
      words_left   <= '0;
    end else begin
      phase        <= phase_next;
      header_count <= header_count_next;
      words_left   <= words_left_next;
    end
  end

endmodule

// ===== hw/rtl/btsp_queue.sv =====
// Small command FIFO between front and back ends.
// Depends on btsp_pkg for the command and status types.
module btsp_queue import btsp_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign head         = entries[rd_ptr];
  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);

  // Storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/btsp_back.sv =====
// Back end: executes queued commands, builds addresses, drives result register.
// Depends on btsp_pkg; pulls from btsp_queue.
module btsp_back import btsp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      head,
  input  logic      head_valid,
  output logic      pop,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res_item
);

  logic [WORD_W-1:0] addr_hi;
  logic [ADDR_W-1:0] block_address;
  logic [ADDR_W-1:0] start_addr;
  logic              emits;

  assign start_addr = {addr_hi, head.word};
  assign emits      = (head.op != OP_ADDR_H);
  // take a command when its result has room, or when it makes none
  assign pop        = head_valid && (!emits || !res_valid || !res_stall);

  // Address state
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_hi       <= '0;
      block_address <= '0;
    end else if (pop) begin
      case (head.op)
        OP_ADDR_H: addr_hi       <= head.word;
        OP_ADDR_L: block_address <= start_addr;
        OP_DATA:   block_address <= block_address + ADDR_W'(1);
        default:   block_address <= block_address;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop && emits) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emits) begin
      case (head.op)
        OP_ADDR_L: begin
          res_item.kind           <= KIND_BLOCK;
          res_item.target_address <= start_addr;
          res_item.data_word      <= head.size;
        end
        OP_DATA: begin
          res_item.kind           <= KIND_DATA;
          res_item.target_address <= block_address;
          res_item.data_word      <= head.word;
        end
        default: begin
          res_item.kind           <= KIND_END;
          res_item.target_address <= '0;
          res_item.data_word      <= '0;
        end
      endcase
    end
  end

endmodule
